/* rtl/dhd_pkg.sv */
// Package for the differential heading drive: shaping limits, angle constants,
// register codes and the command shaping and pin mapping functions.
// No dependencies.
`default_nettype none

package dhd_pkg;

    // Configuration register codes
    localparam logic [1:0] REG_TARGET_SPEED = 2'd0;
    localparam logic [1:0] REG_REF_HEADING  = 2'd1;
    localparam logic [1:0] REG_PULSED_MODE  = 2'd2;
    localparam logic [1:0] REG_DRIVE_ON     = 2'd3;

    // Angle wrap thresholds and offsets, centidegrees, 19-bit signed
    localparam logic signed [18:0] HALF_TURN       = 19'sd18000;
    localparam logic signed [18:0] NEG_HALF_TURN   = -19'sd18000;
    localparam logic signed [18:0] THREE_HALF_TURN = 19'sd54000;
    localparam logic signed [18:0] NEG_THREE_HALF  = -19'sd54000;
    localparam logic signed [18:0] FULL_TURN       = 19'sd36000;
    localparam logic signed [18:0] TWO_TURNS       = 19'sd72000;

    // Offset saturation
    localparam logic signed [18:0] OFFSET_LIMIT     = 19'sd10000;
    localparam logic signed [18:0] NEG_OFFSET_LIMIT = -19'sd10000;

    // Wheel speed clip
    localparam logic signed [16:0] SPEED_LIMIT     = 17'sd16383;
    localparam logic signed [16:0] NEG_SPEED_LIMIT = -17'sd16383;

    // Shaping curve
    localparam logic [13:0] DEAD_ZONE = 14'd1024;
    localparam logic [13:0] KNEE      = 14'd4096;
    localparam logic [13:0] HIGH_BIAS = 14'd8192;
    localparam logic [13:0] LOW_BIAS  = 14'd2048;

    // Pin mapping
    localparam logic [7:0] NEAR_FULL = 8'hFE;
    localparam logic [7:0] FULL_DUTY = 8'hFF;

    typedef struct packed {
        logic [7:0] pwm;
        logic       dir;
    } pin_t;

    // Clip, dead zone, two-slope curve, shift by 7; negatives get one's complement
    function automatic logic [7:0] shape_cmd(input logic signed [16:0] s);
        logic signed [16:0] v;
        logic signed [16:0] mag;
        logic [13:0]        m;
        logic [13:0]        q;
        logic [7:0]         c;
        if (s > SPEED_LIMIT)
            v = SPEED_LIMIT;
        else if (s < NEG_SPEED_LIMIT)
            v = NEG_SPEED_LIMIT;
        else
            v = s;
        mag = v[16] ? -v : v;
        m   = mag[13:0];
        if (m > KNEE)
            q = {1'b0, m[13:1]} + HIGH_BIAS;
        else
            q = {m[12:0], 1'b0} + LOW_BIAS;
        c = {1'b0, q[13:7]};
        if (m <= DEAD_ZONE)
            shape_cmd = 8'd0;
        else if (v[16])
            shape_cmd = ~c;
        else
            shape_cmd = c;
    endfunction

    // Command byte to duty byte and direction; near-full duty becomes full duty
    function automatic pin_t to_pins(input logic [7:0] cmd);
        pin_t p;
        p.pwm = {cmd[6:0], 1'b0};
        if (p.pwm == NEAR_FULL)
            p.pwm = FULL_DUTY;
        p.dir = cmd[7];
        to_pins = p;
    endfunction

endpackage

`default_nettype wire

/* rtl/differential_heading_drive.sv */
// Top level of the differential heading drive: heading error to left and right
// motor duty bytes in a three-register pipeline. Depends on dhd_pkg.
//
//  channel | signals                                    | handshake
//  --------+--------------------------------------------+-------------------
//  in      | heading, ms_low                            | in_valid/in_ready
//  out     | left_pwm, left_dir, right_pwm, right_dir,  | out_valid/out_ready
//          | outputs_driven                             |
//  cfg     | cfg_addr, cfg_wdata                        | cfg_wr_en
//
// One word per cycle while no result waits on out_ready; out_valid is registered through the stages.
// Stages: input register, wrapped offset register, result register.
// Reset clears the valid bits and all configuration registers.
// The whole pipeline holds while a result waits on out_ready; in_ready follows.
`default_nettype none

module differential_heading_drive (
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               cfg_wr_en,
    input  wire logic [1:0]         cfg_addr,
    input  wire logic [15:0]        cfg_wdata,
    input  wire logic               in_valid,
    output logic                    in_ready,
    input  wire logic signed [15:0] heading,
    input  wire logic [7:0]         ms_low,
    output logic                    out_valid,
    input  wire logic               out_ready,
    output logic [7:0]              left_pwm,
    output logic                    left_dir,
    output logic [7:0]              right_pwm,
    output logic                    right_dir,
    output logic                    outputs_driven
);
    import dhd_pkg::*;

    // Configuration registers
    logic signed [14:0] target_speed_reg;
    logic signed [15:0] ref_heading_reg;
    logic               pulsed_mode_reg;
    logic               drive_on_reg;

    // Pipeline valid bits
    logic s1_valid_reg, s2_valid_reg, out_valid_reg;
    logic advance;

    // Stage payload
    logic signed [15:0] s1_heading_reg;
    logic               s1_gate_reg;
    logic signed [14:0] s2_offset_reg;
    logic               s2_gate_reg;
    pin_t               left_reg, right_reg;

    // Stage 1 to 2 logic
    logic signed [16:0] diff;
    logic signed [18:0] diff_ext;
    logic signed [18:0] wrapped;
    logic signed [18:0] gained;
    logic signed [18:0] offset_next;

    // Stage 2 to 3 logic
    logic signed [16:0] left_sum, right_sum;
    logic [7:0]         left_cmd, right_cmd;
    logic               blank;
    pin_t               left_next, right_next;

    assign advance  = !out_valid_reg || out_ready;
    assign in_ready = advance;

    // Take configuration writes
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            target_speed_reg <= '0;
            ref_heading_reg  <= '0;
            pulsed_mode_reg  <= 1'b0;
            drive_on_reg     <= 1'b0;
        end
        else if (cfg_wr_en)
        begin
            case (cfg_addr)
                REG_TARGET_SPEED: target_speed_reg <= cfg_wdata[14:0];
                REG_REF_HEADING:  ref_heading_reg  <= cfg_wdata;
                REG_PULSED_MODE:  pulsed_mode_reg  <= cfg_wdata[0];
                REG_DRIVE_ON:     drive_on_reg     <= cfg_wdata[0];
                default:          drive_on_reg     <= drive_on_reg;
            endcase
        end
    end

    // Wrap the heading error into (-18000, 18000], scale by 5 and clamp to +-10000
    always_comb
    begin
        diff     = {s1_heading_reg[15], s1_heading_reg}
                 - {ref_heading_reg[15], ref_heading_reg};
        diff_ext = {{2{diff[16]}}, diff};
        if (diff_ext > THREE_HALF_TURN)
            wrapped = diff_ext - TWO_TURNS;
        else if (diff_ext > HALF_TURN)
            wrapped = diff_ext - FULL_TURN;
        else if (diff_ext > NEG_HALF_TURN)
            wrapped = diff_ext;
        else if (diff_ext > NEG_THREE_HALF)
            wrapped = diff_ext + FULL_TURN;
        else
            wrapped = diff_ext + TWO_TURNS;
        gained = (wrapped <<< 2) + wrapped;
        if (gained > OFFSET_LIMIT)
            offset_next = OFFSET_LIMIT;
        else if (gained < NEG_OFFSET_LIMIT)
            offset_next = NEG_OFFSET_LIMIT;
        else
            offset_next = gained;
    end

    // Mix offset into both wheels, shape, gate and map to pins
    always_comb
    begin
        left_sum  = {{2{target_speed_reg[14]}}, target_speed_reg}
                  - {{2{s2_offset_reg[14]}}, s2_offset_reg};
        right_sum = {{2{target_speed_reg[14]}}, target_speed_reg}
                  + {{2{s2_offset_reg[14]}}, s2_offset_reg};
        blank     = !drive_on_reg || (pulsed_mode_reg && !s2_gate_reg);
        left_cmd  = blank ? 8'd0 : shape_cmd(left_sum);
        right_cmd = blank ? 8'd0 : ~shape_cmd(right_sum);
        left_next  = to_pins(left_cmd);
        right_next = to_pins(right_cmd);
    end

    // Advance valid bits
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg  <= 1'b0;
            s2_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else if (advance)
        begin
            s1_valid_reg  <= in_valid;
            s2_valid_reg  <= s1_valid_reg;
            out_valid_reg <= s2_valid_reg;
        end
    end

    // Advance payload
    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            s1_heading_reg <= heading;
            s1_gate_reg    <= ms_low[7];
            s2_offset_reg  <= offset_next[14:0];
            s2_gate_reg    <= s1_gate_reg;
            left_reg       <= left_next;
            right_reg      <= right_next;
        end
    end

    assign out_valid      = out_valid_reg;
    assign left_pwm       = left_reg.pwm;
    assign left_dir       = left_reg.dir;
    assign right_pwm      = right_reg.pwm;
    assign right_dir      = right_reg.dir;
    assign outputs_driven = drive_on_reg;

    // Near-full duty never leaves the block
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg |-> (left_reg.pwm != NEAR_FULL) && (right_reg.pwm != NEAR_FULL))
        else $error("near-full duty byte on output");

    // Saturated offset stays within limits
    assert property (@(posedge clk) disable iff (!rst_n)
        s2_valid_reg |-> (s2_offset_reg <= 15'sd10000) && (s2_offset_reg >= -15'sd10000))
        else $error("offset out of range");

    // A stalled result holds
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg && !out_ready |=> out_valid_reg && $stable(left_reg) && $stable(right_reg))
        else $error("stalled result changed");

    // A stalled first-stage word is kept
    assert property (@(posedge clk) disable iff (!rst_n)
        s1_valid_reg && !advance |=> s1_valid_reg && $stable(s1_heading_reg))
        else $error("stalled input word lost");

endmodule

`default_nettype wire

/* dv/dhd_drive_checker.sv */
// Checker for the differential heading drive: watches the configuration port and both
// word channels, predicts each drive word and compares it with what comes out.
// Depends on dhd_pkg for the register codes.
module dhd_drive_checker (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              cfg_wr_en,
    input  logic [1:0]        cfg_addr,
    input  logic [15:0]       cfg_wdata,
    input  logic              in_valid,
    input  logic              in_ready,
    input  logic signed [15:0] heading,
    input  logic [7:0]        ms_low,
    input  logic              out_valid,
    input  logic              out_ready,
    input  logic [7:0]        left_pwm,
    input  logic              left_dir,
    input  logic [7:0]        right_pwm,
    input  logic              right_dir,
    input  logic              outputs_driven,
    output int                fail_count,
    output int                pending
);
    import dhd_pkg::*;

    localparam int WRAP_FULL   = 36000;
    localparam int WRAP_HALF   = 18000;
    localparam int STEER_GAIN  = 5;
    localparam int STEER_SAT   = 10000;
    localparam int WHEEL_SAT   = 16383;
    localparam int DEAD_BAND   = 1024;
    localparam int SLOPE_KNEE  = 4096;
    localparam int UPPER_BIAS  = 8192;
    localparam int LOWER_BIAS  = 2048;
    localparam int CMD_SCALE   = 128;
    localparam logic [7:0] DUTY_NEAR_FULL = 8'hFE;
    localparam logic [7:0] DUTY_FULL      = 8'hFF;
    localparam int REPORT_MAX  = 10;

    typedef struct packed {
        logic [7:0] left_pwm;
        logic       left_dir;
        logic [7:0] right_pwm;
        logic       right_dir;
        logic       driven;
    } drive_word_t;

    // Shadow copy of the configuration registers
    logic signed [14:0] speed_q;
    logic signed [15:0] ref_heading_q;
    logic               pulsed_q;
    logic               drive_on_q;

    drive_word_t drive_words[$];
    int          errors;

    function automatic int clamp_sym(input int v, input int lim);
        if (v > lim)
            return lim;
        if (v < -lim)
            return -lim;
        return v;
    endfunction

    // Clip, dead band, two-slope curve, scale down; negatives get one's complement
    function automatic logic [7:0] wheel_cmd(input int s);
        int         v;
        int         mag;
        int         q;
        logic [7:0] c;
        v   = clamp_sym(s, WHEEL_SAT);
        mag = (v < 0) ? -v : v;
        if (mag <= DEAD_BAND)
            return 8'd0;
        if (mag > SLOPE_KNEE)
            q = mag / 2 + UPPER_BIAS;
        else
            q = mag * 2 + LOWER_BIAS;
        q = q / CMD_SCALE;
        c = q[7:0];
        if (v < 0)
            c = ~c;
        return c;
    endfunction

    function automatic logic [7:0] duty_of(input logic [7:0] c);
        logic [7:0] b;
        b = {c[6:0], 1'b0};
        if (b == DUTY_NEAR_FULL)
            b = DUTY_FULL;
        return b;
    endfunction

    function automatic drive_word_t predict_drive(input logic signed [15:0] hdg,
                                                  input logic [7:0] ms);
        int          err;
        int          offset;
        logic [7:0]  lc;
        logic [7:0]  rc;
        drive_word_t w;
        err = int'(hdg) - int'(ref_heading_q);
        err = err % WRAP_FULL;
        if (err <= -WRAP_HALF)
            err += WRAP_FULL;
        if (err > WRAP_HALF)
            err -= WRAP_FULL;
        offset = clamp_sym(err * STEER_GAIN, STEER_SAT);
        lc = wheel_cmd(int'(speed_q) - offset);
        rc = ~wheel_cmd(int'(speed_q) + offset);
        // Floating outputs or pulse gap force zero drive
        if (!drive_on_q || (pulsed_q && !ms[7]))
        begin
            lc = 8'd0;
            rc = 8'd0;
        end
        w.left_pwm  = duty_of(lc);
        w.left_dir  = lc[7];
        w.right_pwm = duty_of(rc);
        w.right_dir = rc[7];
        w.driven    = drive_on_q;
        return w;
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        drive_word_t want;
        drive_word_t got;
        if (!rst_n)
        begin
            speed_q       = '0;
            ref_heading_q = '0;
            pulsed_q      = 1'b0;
            drive_on_q    = 1'b0;
            drive_words.delete();
            errors        = 0;
            fail_count   <= 0;
            pending      <= 0;
        end
        else
        begin
            // Compare the delivered word with the oldest prediction
            if (out_valid && out_ready)
            begin
                got = {left_pwm, left_dir, right_pwm, right_dir, outputs_driven};
                if (drive_words.size() == 0)
                begin
                    if (errors < REPORT_MAX)
                        $display("mismatch: unexpected word pwm %0h/%0h dir %0b/%0b drv %0b",
                                 left_pwm, right_pwm, left_dir, right_dir, outputs_driven);
                    errors++;
                end
                else
                begin
                    want = drive_words.pop_front();
                    if (got.left_pwm !== want.left_pwm || got.left_dir !== want.left_dir ||
                        got.right_pwm !== want.right_pwm ||
                        got.right_dir !== want.right_dir || got.driven !== want.driven)
                    begin
                        if (errors < REPORT_MAX)
                        begin
                            $write("mismatch: expected pwm %0h/%0h dir %0b/%0b drv %0b,",
                                   want.left_pwm, want.right_pwm, want.left_dir,
                                   want.right_dir, want.driven);
                            $display(" got pwm %0h/%0h dir %0b/%0b drv %0b",
                                     got.left_pwm, got.right_pwm, got.left_dir,
                                     got.right_dir, got.driven);
                        end
                        errors++;
                    end
                end
            end
            // Predict each accepted heading word with the current settings
            if (in_valid && in_ready)
                drive_words.push_back(predict_drive(heading, ms_low));
            // Track register writes
            if (cfg_wr_en)
            begin
                case (cfg_addr)
                    REG_TARGET_SPEED: speed_q       = cfg_wdata[14:0];
                    REG_REF_HEADING:  ref_heading_q = cfg_wdata;
                    REG_PULSED_MODE:  pulsed_q      = cfg_wdata[0];
                    REG_DRIVE_ON:     drive_on_q    = cfg_wdata[0];
                    default: ;
                endcase
            end
            fail_count <= errors;
            pending    <= drive_words.size();
        end
    end

endmodule

/* dv/tb_top.sv */
// Testbench top for differential_heading_drive: clock, reset, register setup,
// directed and random heading words with random stalls, and the verdict.
// Depends on dhd_pkg, the block and dhd_drive_checker.
module tb_top;
    import dhd_pkg::*;

    localparam int CYCLE_LIMIT   = 600000;
    localparam int SETTLE_CYCLES = 6;
    localparam int RAND_PHASES   = 16;
    localparam int PHASE_WORDS   = 100;

    logic               clk = 1'b0;
    logic               rst_n = 1'b0;
    logic               cfg_wr_en = 1'b0;
    logic [1:0]         cfg_addr = '0;
    logic [15:0]        cfg_wdata = '0;
    logic               in_valid = 1'b0;
    logic               in_ready;
    logic signed [15:0] heading = '0;
    logic [7:0]         ms_low = '0;
    logic               out_valid;
    logic               out_ready = 1'b0;
    logic [7:0]         left_pwm;
    logic               left_dir;
    logic [7:0]         right_pwm;
    logic               right_dir;
    logic               outputs_driven;
    int                 fail_count;
    int                 pending;
    logic               no_stall = 1'b0;

    always #1 clk = ~clk;

    differential_heading_drive u_dut (
        .clk            (clk),
        .rst_n          (rst_n),
        .cfg_wr_en      (cfg_wr_en),
        .cfg_addr       (cfg_addr),
        .cfg_wdata      (cfg_wdata),
        .in_valid       (in_valid),
        .in_ready       (in_ready),
        .heading        (heading),
        .ms_low         (ms_low),
        .out_valid      (out_valid),
        .out_ready      (out_ready),
        .left_pwm       (left_pwm),
        .left_dir       (left_dir),
        .right_pwm      (right_pwm),
        .right_dir      (right_dir),
        .outputs_driven (outputs_driven)
    );

    dhd_drive_checker u_checker (
        .clk            (clk),
        .rst_n          (rst_n),
        .cfg_wr_en      (cfg_wr_en),
        .cfg_addr       (cfg_addr),
        .cfg_wdata      (cfg_wdata),
        .in_valid       (in_valid),
        .in_ready       (in_ready),
        .heading        (heading),
        .ms_low         (ms_low),
        .out_valid      (out_valid),
        .out_ready      (out_ready),
        .left_pwm       (left_pwm),
        .left_dir       (left_dir),
        .right_pwm      (right_pwm),
        .right_dir      (right_dir),
        .outputs_driven (outputs_driven),
        .fail_count     (fail_count),
        .pending        (pending)
    );

    // Mostly short gaps, a few long ones, none in steady stretches
    function automatic int pick_gap();
        int r;
        if (no_stall)
            return 0;
        r = $urandom_range(99);
        if (r < 70)
            return 0;
        if (r < 95)
            return $urandom_range(1, 3);
        return $urandom_range(8, 40);
    endfunction

    // Stall the result side at random
    initial
    begin
        int gap;
        forever
        begin
            gap = pick_gap();
            if (gap > 0)
            begin
                out_ready <= 1'b0;
                repeat (gap) @(posedge clk);
            end
            out_ready <= 1'b1;
            repeat ($urandom_range(1, 12)) @(posedge clk);
        end
    end

    // Offer one heading word and hold it until accepted
    task automatic send_word(input logic signed [15:0] hdg, input logic [7:0] ms);
        int gap;
        gap = pick_gap();
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        heading  <= hdg;
        ms_low   <= ms;
        in_valid <= 1'b1;
        @(posedge clk);
        while (!in_ready)
            @(posedge clk);
    endtask

    // Drop valid and wait until every predicted word has come out
    task automatic drain();
        in_valid <= 1'b0;
        @(posedge clk);
        while (pending != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    // Write all four registers back to back; unused upper data bits are random
    task automatic write_regs(input logic signed [14:0] speed,
                              input logic signed [15:0] ref_hdg,
                              input logic pulse, input logic drive);
        cfg_wr_en <= 1'b1;
        cfg_addr  <= REG_TARGET_SPEED;
        cfg_wdata <= {1'($urandom_range(1)), speed};
        @(posedge clk);
        cfg_addr  <= REG_REF_HEADING;
        cfg_wdata <= ref_hdg;
        @(posedge clk);
        cfg_addr  <= REG_PULSED_MODE;
        cfg_wdata <= {15'($urandom), pulse};
        @(posedge clk);
        cfg_addr  <= REG_DRIVE_ON;
        cfg_wdata <= {15'($urandom), drive};
        @(posedge clk);
        cfg_wr_en <= 1'b0;
    endtask

    function automatic logic signed [15:0] rand_heading(input logic signed [15:0] ref_hdg);
        int r;
        int v;
        r = $urandom_range(99);
        if (r < 65)
            v = $urandom_range(36000) - 18000;
        else if (r < 85)
            v = int'(ref_hdg) + $urandom_range(600) - 300;
        else
            v = $urandom;
        return v[15:0];
    endfunction

    function automatic logic signed [14:0] rand_speed();
        int r;
        int v;
        r = $urandom_range(9);
        case (r)
            0: v = 16383;
            1: v = -16384;
            2: v = 0;
            3: v = $urandom_range(2400) - 1200;
            default: v = $urandom;
        endcase
        return v[14:0];
    endfunction

    function automatic logic signed [15:0] rand_ref();
        int v;
        if ($urandom_range(4) == 0)
            v = $urandom;
        else
            v = $urandom_range(35999) - 17999;
        return v[15:0];
    endfunction

    // Give up on a hung run
    initial
    begin
        repeat (CYCLE_LIMIT) @(posedge clk);
        $display("simulation failed");
        $finish;
    end

    initial
    begin
        int                 speed_pts[8];
        logic signed [15:0] ref_hdg;
        speed_pts = '{1024, 1025, 4096, 4097, 16383, -16384, -1025, -4097};
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Floating outputs straight after reset
        send_word(16'sd0, 8'h00);
        send_word(16'sd18000, 8'hFF);
        send_word(-16'sd18000, 8'h80);
        drain();

        // Shaping edges: dead band, knee, full duty, negative side
        foreach (speed_pts[i])
        begin
            write_regs(speed_pts[i][14:0], 16'sd0, 1'b0, 1'b1);
            send_word(16'sd0, 8'h5A);
            send_word(16'sd2000, 8'hA5);
            drain();
        end

        // Pulse gap and out-of-range headings
        write_regs(15'sd0, 16'sd18000, 1'b1, 1'b1);
        send_word(-16'sd18000, 8'h7F);
        send_word(-16'sd17999, 8'h80);
        send_word(16'h8000, 8'h80);
        send_word(16'h7FFF, 8'hFF);
        drain();
        write_regs(-15'sd16384, -16'sd17999, 1'b0, 1'b1);
        send_word(16'sd18000, 8'h00);
        send_word(16'sd0, 8'h00);
        drain();

        // Random settings, each followed by a run of random headings
        for (int p = 0; p < RAND_PHASES; p++)
        begin
            ref_hdg = rand_ref();
            write_regs(rand_speed(), ref_hdg, 1'($urandom_range(1)),
                       ($urandom_range(6) != 0));
            no_stall <= ((p % 4) == 3);
            repeat (PHASE_WORDS)
                send_word(rand_heading(ref_hdg), 8'($urandom_range(255)));
            drain();
        end

        // Verdict
        if (fail_count == 0)
            $display("simulation ok");
        else
            $display("simulation failed");
        $finish;
    end

endmodule
